/* hw/rtl/closest_pair_of_points_defines.svh */
// Assertion macros for the checker file of the closest-pair block.
// Depends on nothing; include by bare file name.
`ifndef CLOSEST_PAIR_OF_POINTS_DEFINES_SVH
`define CLOSEST_PAIR_OF_POINTS_DEFINES_SVH

// Assert that a condition implies a property on the next clock edge.
`define CPP_ASSERT_NEXT(label, clk, rstn, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error("assertion failed");

// Assert that a condition holds in the same cycle.
`define CPP_ASSERT_NOW(label, clk, rstn, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error("assertion failed");

`endif

/* hw/rtl/cpp_pkg.sv */
// Package for the closest-pair block: sizes and status codes.
// Used by the top level and its arithmetic units.
package cpp_pkg;
  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned FracBitsDef  = 20;
  localparam int unsigned CoordW       = 31;
  localparam int unsigned SqW          = 63;
  localparam int unsigned RootW        = 52;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusTooFew   = 2'd1,
    StatusOverflow = 2'd2
  } status_e;
endpackage

/* hw/rtl/cpp_sqrt.sv */
// Bit-serial fixed-point square root: one result bit per cycle.
// Depends on cpp_pkg.
module cpp_sqrt #(
  parameter int unsigned FracBits = cpp_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cpp_pkg::SqW-1:0]   radicand_i,
  output logic                      done_o,
  output logic [cpp_pkg::RootW-1:0] root_o
);
  import cpp_pkg::*;
  localparam int unsigned Steps = 32 + FracBits;
  localparam int unsigned OpW   = 2 * Steps;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [OpW-1:0]   op_q, op_d;
  logic [Steps+1:0] rem_q, rem_d;
  logic [Steps-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [Steps+1:0] trial, shifted;

  // One restoring step per cycle on the top two radicand bits
  always_comb begin
    op_d = op_q; rem_d = rem_q; root_d = root_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[Steps-1:0], op_q[OpW-1 -: 2]};
    trial   = {root_q, 2'b01};
    if (start_i) begin
      op_d   = OpW'(radicand_i) << (2 * FracBits);
      rem_d  = '0; root_d = '0;
      cnt_d  = CntW'(Steps); busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = op_q << 2;
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[Steps-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[Steps-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; rem_q <= rem_d; root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = RootW'(root_q);
endmodule

/* hw/rtl/closest_pair_of_points.sv */
// Top level of the closest-pair block: point store, pair sequencer, result.
// Depends on cpp_pkg and cpp_sqrt.
//
// Points arrive on the s_axis channel, one item per cycle while loading;
// tdata = {point_y, point_x}, tlast marks the final point of the set.
// Points past MAX_POINTS are dropped and flagged with status 2.
// After tlast the block accepts nothing and walks all pairs i<j with one
// shared distance unit: memory read, difference, squares, sum and compare
// each take a register stage; the scan is set by the single read port of
// the store, and each row first fetches its pivot.
// A fixed-point square root then follows, one bit a cycle.
// Fewer than two points give status 1 with zero distances at once.
// One result item appears on m_axis; tdata = {root, min_dist_sq},
// tuser = result_status. It is held in the output register while the
// receiver stalls, and the next set is taken only after it is delivered.
// Reset empties the set; the store itself needs no clearing.
module closest_pair_of_points #(
  parameter int unsigned MAX_POINTS = cpp_pkg::MaxPointsDef,
  parameter int unsigned FRAC_BITS  = cpp_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // [30:0] point_x, [61:31] point_y
  input  logic         s_axis_tlast,  // last_point
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // [62:0] min_dist_sq, [114:63] min_dist_root
  output logic [1:0]   m_axis_tuser   // result_status
);
  import cpp_pkg::*;
  localparam int unsigned IdxW = $clog2(MAX_POINTS);
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]      state_q;
  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic [IdxW-1:0] i_q, j_q;
  logic            fetch_i_q;
  logic [2*CoordW-1:0] mem_q [MAX_POINTS];
  logic [2*CoordW-1:0] rd_q, pi_q;
  logic [3:0]      vld_q;
  logic [3:0]      drain_q;
  logic signed [CoordW:0] dx_q, dy_q;
  logic [CoordW-1:0]   adx, ady;
  logic [2*CoordW-1:0] sqx, sqy;
  logic [63:0]     sx_q, sy_q, sum_q, best_q;
  logic            sq_start;
  logic            sq_done;
  logic [RootW-1:0] sq_root;
  logic [SqW-1:0]  res_sq_q;
  logic [RootW-1:0] res_root_q;
  logic [StatusW-1:0] res_st_q;
  logic            in_fire, out_fire;
  logic            piv_ld_q;

  assign s_axis_tready = (state_q == StLoad);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Write the store while loading, read one entry a cycle while scanning
  always_ff @(posedge clk_i) begin
    if (in_fire && (count_q < CntW'(MAX_POINTS)))
      mem_q[count_q[IdxW-1:0]] <= s_axis_tdata[2*CoordW-1:0];
    rd_q <= mem_q[fetch_i_q ? i_q : j_q];
  end

  // Take magnitudes so each square is an unsigned 31 by 31 product
  assign adx = dx_q[CoordW] ? CoordW'(-dx_q) : dx_q[CoordW-1:0];
  assign ady = dy_q[CoordW] ? CoordW'(-dy_q) : dy_q[CoordW-1:0];
  assign sqx = (2*CoordW)'(adx) * (2*CoordW)'(adx);
  assign sqy = (2*CoordW)'(ady) * (2*CoordW)'(ady);

  // Distance pipeline: difference, squares, sum, running minimum
  always_ff @(posedge clk_i) begin
    dx_q <= $signed({rd_q[CoordW-1], rd_q[CoordW-1:0]})
          - $signed({pi_q[CoordW-1], pi_q[CoordW-1:0]});
    dy_q <= $signed({rd_q[2*CoordW-1], rd_q[2*CoordW-1:CoordW]})
          - $signed({pi_q[2*CoordW-1], pi_q[2*CoordW-1:CoordW]});
    sx_q <= 64'(sqx);
    sy_q <= 64'(sqy);
    sum_q <= sx_q + sy_q;
  end

  assign sq_start = (state_q == StDrain) && (drain_q == 4'd0);

  cpp_sqrt #(.FracBits(FRAC_BITS)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i(best_q[SqW-1:0]),
    .done_o(sq_done), .root_o(sq_root)
  );

  // Sequencer: load, scan pairs, drain pipeline, root, present
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; count_q <= '0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; fetch_i_q <= 1'b0; vld_q <= '0;
      drain_q <= '0; best_q <= '1;
      res_sq_q <= '0; res_root_q <= '0; res_st_q <= StatusOk;
    end else begin
      vld_q <= {vld_q[2:0], (state_q == StScan) && !fetch_i_q};
      unique case (state_q)
        StLoad: if (in_fire) begin
          if (count_q < CntW'(MAX_POINTS)) count_q <= count_q + 1'b1;
          else ovf_q <= 1'b1;
          if (s_axis_tlast) begin
            best_q <= '1; i_q <= '0; fetch_i_q <= 1'b1;
            if (count_q < CntW'(MAX_POINTS) ? count_q >= CntW'(1)
                                            : 1'b1) state_q <= StScan;
            else begin
              res_st_q <= StatusTooFew; res_sq_q <= '0; res_root_q <= '0;
              state_q <= StOut;
            end
          end
        end
        StScan: begin
          if (vld_q[3] && sum_q < best_q) best_q <= sum_q;
          if (fetch_i_q) begin
            // rd_q gets entry i next cycle; then stream j = i+1..
            fetch_i_q <= 1'b0; j_q <= i_q + 1'b1;
          end else begin
            if ({1'b0, j_q} == CntW'(count_q - 1'b1)) begin
              if ({1'b0, i_q} == CntW'(count_q - 2'd2)) begin
                state_q <= StDrain; drain_q <= 4'd6;
              end else begin
                i_q <= i_q + 1'b1; fetch_i_q <= 1'b1;
              end
            end else j_q <= j_q + 1'b1;
          end
        end
        StDrain: begin
          if (vld_q[3] && sum_q < best_q) best_q <= sum_q;
          if (drain_q == 4'd0) state_q <= StRoot;
          else drain_q <= drain_q - 1'b1;
        end
        StRoot: if (sq_done) begin
          res_sq_q <= best_q[SqW-1:0]; res_root_q <= sq_root;
          res_st_q <= ovf_q ? StatusOverflow : StatusOk;
          state_q <= StOut;
        end
        StOut: if (out_fire) begin
          state_q <= StLoad; count_q <= '0; ovf_q <= 1'b0; best_q <= '1;
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // Hold entry i as the pivot; rd_q carries it in the cycle after the i fetch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) piv_ld_q <= 1'b0;
    else piv_ld_q <= (state_q == StScan) && fetch_i_q;
  end
  always_ff @(posedge clk_i) if (piv_ld_q) pi_q <= rd_q;

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {5'd0, res_root_q, res_sq_q};
  assign m_axis_tuser  = res_st_q;
endmodule

/* hw/rtl/cpp_checker.sv */
// Port-level checker for the closest-pair block, bound to the top level.
// Depends on cpp_pkg and closest_pair_of_points_defines.svh.
`include "closest_pair_of_points_defines.svh"
module cpp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import cpp_pkg::*;
  logic out_wait, in_last;

  assign out_wait = m_axis_tvalid && !m_axis_tready;
  assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  `CPP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_wait, $stable(m_axis_tdata))
  `CPP_ASSERT_NOW(a_excl, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `CPP_ASSERT_NEXT(a_last, clk_i, rst_ni, in_last, !s_axis_tready)
  `CPP_ASSERT_NOW(a_few, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == StatusTooFew, m_axis_tdata == '0)
endmodule

bind closest_pair_of_points cpp_checker u_cpp_checker (.*);
